// File: hdl/assert_macros.svh
// Assertion macros used by the top level of the timed task event queue.
// No dependencies; the user supplies clock and reset names in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: hdl/tteq_pkg.sv
// Package for the timed task event queue: widths, codes, FSM state type,
// controller/datapath command and status structs, and time compare helpers.
// No dependencies.
`default_nettype none

package tteq_pkg;

   localparam int MAX_TASKS      = 16;
   localparam int ID_W           = 4;
   localparam int CNT_W          = 5;
   localparam int TIME_W         = 32;
   localparam int POST_DEPTH_DEF = 8;

   localparam logic [3:0] MODE_STEP        = 4'd0;
   localparam logic [3:0] MODE_AT_NOW      = 4'd1;
   localparam logic [3:0] MODE_AT_TIME     = 4'd2;
   localparam logic [3:0] MODE_IN_OFFSET   = 4'd3;
   localparam logic [3:0] MODE_RESCHED_IN  = 4'd4;
   localparam logic [3:0] MODE_RESCHED_NOW = 4'd5;
   localparam logic [3:0] MODE_POST        = 4'd6;
   localparam logic [3:0] MODE_REMOVE      = 4'd7;
   localparam logic [3:0] MODE_STATUS      = 4'd8;
   localparam logic [3:0] MODE_CLEAR       = 4'd9;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_NOCUR  = 2'd1;
   localparam logic [1:0] ERR_FULL   = 2'd2;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_TASK  = 2'd1;
   localparam logic [1:0] KIND_IDLE  = 2'd2;

   localparam logic [1:0] STAT_IDLE      = 2'd0;
   localparam logic [1:0] STAT_ACTIVE    = 2'd1;
   localparam logic [1:0] STAT_RUNNABLE  = 2'd2;
   localparam logic [1:0] STAT_SCHEDULED = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH,
      ST_REMOVE,
      ST_INSERT,
      ST_DISPATCH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic latch;
      logic load_req;
      logic load_fifo;
      logic remove;
      logic insert;
      logic dispatch;
      logic push;
      logic query;
      logic clear;
      logic drop_cur;
      logic err_nocur;
   } cmd_type;

   typedef struct packed {
      logic [3:0] mode;
      logic       cur_valid;
      logic       fifo_empty;
   } stat_type;

   // Time a precedes time b when a - b, read as two's complement, is negative.
   function automatic logic precedes(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] d;
      d = a - b;
      return d[TIME_W-1];
   endfunction

   function automatic logic follows(input logic [TIME_W-1:0] a,
                                    input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] d;
      d = a - b;
      return (d != '0) && !d[TIME_W-1];
   endfunction

endpackage

`default_nettype wire

// File: hdl/tteq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tteq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: hdl/tteq_ctrl.sv
// Controller state machine of the timed task event queue.
// Depends on tteq_pkg for the state type and the command/status structs.
`default_nettype none

module tteq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire tteq_pkg::stat_type stat,
   output tteq_pkg::cmd_type       cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   tteq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tteq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         tteq_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = tteq_pkg::ST_DECODE;
            end
         end
         tteq_pkg::ST_DECODE: begin
            state_in = tteq_pkg::ST_RESPOND;
            unique case (stat.mode)
               tteq_pkg::MODE_STEP: begin
                  cmd.drop_cur = 1'b1;
                  state_in = stat.fifo_empty ? tteq_pkg::ST_DISPATCH : tteq_pkg::ST_FETCH;
               end
               tteq_pkg::MODE_AT_NOW, tteq_pkg::MODE_AT_TIME, tteq_pkg::MODE_IN_OFFSET,
               tteq_pkg::MODE_REMOVE: begin
                  cmd.load_req = 1'b1;
                  state_in     = tteq_pkg::ST_REMOVE;
               end
               tteq_pkg::MODE_RESCHED_IN, tteq_pkg::MODE_RESCHED_NOW: begin
                  if (stat.cur_valid) begin
                     cmd.load_req = 1'b1;
                     state_in     = tteq_pkg::ST_REMOVE;
                  end else begin
                     cmd.err_nocur = 1'b1;
                  end
               end
               tteq_pkg::MODE_POST:   cmd.push  = 1'b1;
               tteq_pkg::MODE_STATUS: cmd.query = 1'b1;
               tteq_pkg::MODE_CLEAR:  cmd.clear = 1'b1;
               default: ;
            endcase
         end
         tteq_pkg::ST_FETCH: begin
            cmd.load_fifo = 1'b1;
            state_in      = tteq_pkg::ST_REMOVE;
         end
         tteq_pkg::ST_REMOVE: begin
            cmd.remove = 1'b1;
            state_in = (stat.mode == tteq_pkg::MODE_REMOVE) ? tteq_pkg::ST_RESPOND
                                                            : tteq_pkg::ST_INSERT;
         end
         tteq_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
            if (stat.mode == tteq_pkg::MODE_STEP) begin
               state_in = stat.fifo_empty ? tteq_pkg::ST_DISPATCH : tteq_pkg::ST_FETCH;
            end else begin
               state_in = tteq_pkg::ST_RESPOND;
            end
         end
         tteq_pkg::ST_DISPATCH: begin
            cmd.dispatch = 1'b1;
            state_in     = tteq_pkg::ST_RESPOND;
         end
         tteq_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
            state_in  = tteq_pkg::ST_IDLE;
         end
         default: state_in = tteq_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/tteq_dpath.sv
// Datapath of the timed task event queue: sorted list registers, post FIFO,
// current task, configuration register and result registers.
// Depends on tteq_pkg and tteq_ram.
`default_nettype none

module tteq_dpath #(
   parameter int POST_DEPTH = tteq_pkg::POST_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tteq_pkg::cmd_type            cmd,
   output tteq_pkg::stat_type                stat,
   input  wire logic [3:0]                   req_mode,
   input  wire logic [tteq_pkg::ID_W-1:0]    req_task_id,
   input  wire logic [tteq_pkg::TIME_W-1:0]  req_due_time,
   input  wire logic signed [31:0]           req_delay,
   input  wire logic [tteq_pkg::TIME_W-1:0]  req_now,
   input  wire logic                         csr_valid,
   input  wire logic [tteq_pkg::ID_W-1:0]    csr_idle_task_id,
   output logic [1:0]                        rsp_err,
   output logic [1:0]                        rsp_dispatch_kind,
   output logic [tteq_pkg::ID_W-1:0]         rsp_dispatched_task,
   output logic [1:0]                        rsp_task_status,
   output logic                              rsp_found,
   output logic [tteq_pkg::CNT_W-1:0]        rsp_task_count,
   output logic                              rsp_head_valid,
   output logic [tteq_pkg::ID_W-1:0]         rsp_head_task,
   output logic [tteq_pkg::TIME_W-1:0]       rsp_head_time
);

   localparam int MaxT  = tteq_pkg::MAX_TASKS;
   localparam int IdW   = tteq_pkg::ID_W;
   localparam int CntW  = tteq_pkg::CNT_W;
   localparam int TimeW = tteq_pkg::TIME_W;
   localparam int PtrW  = $clog2(POST_DEPTH);
   localparam int FillW = $clog2(POST_DEPTH + 1);

   logic [3:0]        req_mode_ff, req_mode_in;
   logic [IdW-1:0]    req_id_ff, req_id_in;
   logic [TimeW-1:0]  req_due_ff, req_due_in;
   logic [31:0]       req_delay_ff, req_delay_in;
   logic [TimeW-1:0]  req_now_ff, req_now_in;

   logic [IdW-1:0]    order_ff [MaxT];
   logic [IdW-1:0]    order_in [MaxT];
   logic [TimeW-1:0]  due_ff [MaxT];
   logic [TimeW-1:0]  due_in [MaxT];
   logic [CntW-1:0]   len_ff, len_in;

   logic              cur_valid_ff, cur_valid_in;
   logic [IdW-1:0]    cur_task_ff, cur_task_in;
   logic [TimeW-1:0]  cur_due_ff, cur_due_in;

   logic [IdW-1:0]    ins_id_ff, ins_id_in;
   logic [TimeW-1:0]  ins_time_ff, ins_time_in;

   logic [PtrW-1:0]   rd_ff, rd_in;
   logic [PtrW-1:0]   wr_ff, wr_in;
   logic [FillW-1:0]  fill_ff, fill_in;
   logic              fifo_we;
   logic [IdW-1:0]    fifo_rdata;

   logic [IdW-1:0]    idle_ff, idle_in;

   logic [1:0]        err_ff, err_in;
   logic [1:0]        kind_ff, kind_in;
   logic [IdW-1:0]    disp_ff, disp_in;
   logic [1:0]        status_ff, status_in;
   logic              found_ff, found_in;

   logic [MaxT-1:0]   valid;
   logic [MaxT-1:0]   match;
   logic [MaxT-1:0]   rm_after;
   logic [MaxT-1:0]   ins_p;
   logic [MaxT-1:0]   ins_after;
   logic [IdW-1:0]    sel_id;
   logic [TimeW-1:0]  sel_due;
   logic              hit;
   logic              head_ok;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(POST_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   tteq_ram #(
      .WIDTH (IdW),
      .DEPTH (POST_DEPTH)
   ) u_post_ram (
      .clock (clock),
      .we    (fifo_we),
      .waddr (wr_ff),
      .wdata (req_id_ff),
      .raddr (rd_ff),
      .rdata (fifo_rdata)
   );

   // List search: membership, removal point and sorted insertion point.
   always_comb begin
      sel_id  = cmd.query ? req_id_ff : ins_id_ff;
      sel_due = '0;
      for (int i = 0; i < MaxT; i++) begin
         valid[i] = CntW'(i) < len_ff;
         match[i] = valid[i] && (order_ff[i] == sel_id);
         ins_p[i] = valid[i] && tteq_pkg::precedes(ins_time_ff, due_ff[i]);
         if (match[i]) begin
            sel_due = sel_due | due_ff[i];
         end
      end
      rm_after[0]  = match[0];
      ins_after[0] = ins_p[0];
      for (int i = 1; i < MaxT; i++) begin
         rm_after[i]  = rm_after[i-1] | match[i];
         ins_after[i] = ins_after[i-1] | ins_p[i];
      end
      hit     = rm_after[MaxT-1];
      head_ok = (len_ff != '0) && !tteq_pkg::follows(due_ff[0], req_now_ff);
   end

   always_comb begin
      req_mode_in  = req_mode_ff;
      req_id_in    = req_id_ff;
      req_due_in   = req_due_ff;
      req_delay_in = req_delay_ff;
      req_now_in   = req_now_ff;
      order_in     = order_ff;
      due_in       = due_ff;
      len_in       = len_ff;
      cur_valid_in = cur_valid_ff;
      cur_task_in  = cur_task_ff;
      cur_due_in   = cur_due_ff;
      ins_id_in    = ins_id_ff;
      ins_time_in  = ins_time_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      fill_in      = fill_ff;
      fifo_we      = 1'b0;
      idle_in      = idle_ff;
      err_in       = err_ff;
      kind_in      = kind_ff;
      disp_in      = disp_ff;
      status_in    = status_ff;
      found_in     = found_ff;

      if (csr_valid) begin
         idle_in = csr_idle_task_id;
      end

      if (cmd.latch) begin
         req_mode_in  = req_mode;
         req_id_in    = req_task_id;
         req_due_in   = req_due_time;
         req_delay_in = $unsigned(req_delay);
         req_now_in   = req_now;
         err_in       = tteq_pkg::ERR_NONE;
         kind_in      = tteq_pkg::KIND_NONE;
         disp_in      = '0;
         status_in    = tteq_pkg::STAT_IDLE;
         found_in     = 1'b0;
      end

      if (cmd.load_req) begin
         ins_id_in   = req_id_ff;
         ins_time_in = req_now_ff;
         case (req_mode_ff)
            tteq_pkg::MODE_AT_TIME:    ins_time_in = req_due_ff;
            tteq_pkg::MODE_IN_OFFSET:  ins_time_in = req_now_ff + req_delay_ff;
            tteq_pkg::MODE_RESCHED_IN: begin
               ins_id_in   = cur_task_ff;
               ins_time_in = cur_due_ff + req_delay_ff;
            end
            tteq_pkg::MODE_RESCHED_NOW: ins_id_in = cur_task_ff;
            default: ;
         endcase
      end

      if (cmd.load_fifo) begin
         ins_id_in   = fifo_rdata;
         ins_time_in = req_now_ff;
         rd_in       = next_ptr(rd_ff);
         fill_in     = fill_ff - 1'b1;
      end

      if (cmd.remove) begin
         for (int i = 0; i < MaxT - 1; i++) begin
            if (rm_after[i]) begin
               order_in[i] = order_ff[i+1];
               due_in[i]   = due_ff[i+1];
            end
         end
         if (hit) begin
            len_in = len_ff - 1'b1;
         end
         if (req_mode_ff == tteq_pkg::MODE_REMOVE) begin
            found_in = hit;
         end
      end

      // The new entry lands before the first entry it precedes, else at the tail.
      if (cmd.insert) begin
         for (int i = 0; i < MaxT; i++) begin
            if ((ins_p[i] && (i == 0 || !ins_after[i-1])) ||
                (!ins_after[MaxT-1] && CntW'(i) == len_ff)) begin
               order_in[i] = ins_id_ff;
               due_in[i]   = ins_time_ff;
            end else if (i > 0 && ins_after[i]) begin
               order_in[i] = order_ff[i-1];
               due_in[i]   = due_ff[i-1];
            end
         end
         len_in = len_ff + 1'b1;
         if (ins_id_ff == cur_task_ff) begin
            cur_due_in = ins_time_ff;
         end
      end

      if (cmd.dispatch) begin
         if (head_ok) begin
            kind_in      = tteq_pkg::KIND_TASK;
            disp_in      = order_ff[0];
            cur_valid_in = 1'b1;
            cur_task_in  = order_ff[0];
            cur_due_in   = due_ff[0];
            for (int i = 0; i < MaxT - 1; i++) begin
               order_in[i] = order_ff[i+1];
               due_in[i]   = due_ff[i+1];
            end
            len_in = len_ff - 1'b1;
         end else begin
            kind_in = tteq_pkg::KIND_IDLE;
            disp_in = idle_ff;
         end
      end

      if (cmd.drop_cur) begin
         cur_valid_in = 1'b0;
      end

      if (cmd.err_nocur) begin
         err_in = tteq_pkg::ERR_NOCUR;
      end

      if (cmd.push) begin
         if (fill_ff == FillW'(POST_DEPTH)) begin
            err_in = tteq_pkg::ERR_FULL;
         end else begin
            fifo_we = 1'b1;
            wr_in   = next_ptr(wr_ff);
            fill_in = fill_ff + 1'b1;
         end
      end

      if (cmd.query) begin
         priority if (cur_valid_ff && cur_task_ff == req_id_ff) begin
            status_in = tteq_pkg::STAT_ACTIVE;
         end else if (!hit) begin
            status_in = tteq_pkg::STAT_IDLE;
         end else if (!tteq_pkg::follows(sel_due, req_now_ff)) begin
            status_in = tteq_pkg::STAT_RUNNABLE;
         end else begin
            status_in = tteq_pkg::STAT_SCHEDULED;
         end
      end

      if (cmd.clear) begin
         len_in       = '0;
         rd_in        = '0;
         wr_in        = '0;
         fill_in      = '0;
         cur_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         fill_ff      <= '0;
         cur_valid_ff <= 1'b0;
         cur_task_ff  <= '0;
         idle_ff      <= '0;
      end else begin
         len_ff       <= len_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         fill_ff      <= fill_in;
         cur_valid_ff <= cur_valid_in;
         cur_task_ff  <= cur_task_in;
         idle_ff      <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      req_mode_ff  <= req_mode_in;
      req_id_ff    <= req_id_in;
      req_due_ff   <= req_due_in;
      req_delay_ff <= req_delay_in;
      req_now_ff   <= req_now_in;
      order_ff     <= order_in;
      due_ff       <= due_in;
      cur_due_ff   <= cur_due_in;
      ins_id_ff    <= ins_id_in;
      ins_time_ff  <= ins_time_in;
      err_ff       <= err_in;
      kind_ff      <= kind_in;
      disp_ff      <= disp_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
   end

   always_comb begin
      stat.mode       = req_mode_ff;
      stat.cur_valid  = cur_valid_ff;
      stat.fifo_empty = (fill_ff == '0);
   end

   assign rsp_err             = err_ff;
   assign rsp_dispatch_kind   = kind_ff;
   assign rsp_dispatched_task = disp_ff;
   assign rsp_task_status     = status_ff;
   assign rsp_found           = found_ff;
   assign rsp_task_count      = len_ff;
   assign rsp_head_valid      = (len_ff != '0);
   assign rsp_head_task       = (len_ff != '0) ? order_ff[0] : '0;
   assign rsp_head_time       = (len_ff != '0) ? due_ff[0] : '0;

endmodule

`default_nettype wire

// File: hdl/timed_task_event_queue.sv
// Top level of the timed task event queue: controller plus datapath.
// Depends on tteq_pkg, tteq_ctrl, tteq_dpath and assert_macros.svh.
//
// Use: drive req_* with start while busy is low; the word is taken at that
// edge and busy rises. Exactly one result word per request appears on rsp_*
// for one cycle with rsp_valid high; the receiver cannot stall it, so it
// must sample on that cycle. busy falls the cycle after rsp_valid.
// Path from accept to rsp_valid: every request passes DECODE and ends in
// RESPOND. Status, post, clear and the no-current reschedule error need no
// more; remove adds REMOVE; schedule and reschedule add the remove-then-insert
// sequence REMOVE, INSERT of the sorted list; a step runs FETCH, REMOVE, INSERT
// per posted word drained, then DISPATCH. One list update per cycle. One request is in flight at a time.
// The idle task id is written on csr_* at any time the block is idle;
// csr_ready is always high. Reset (synchronous, active high) empties the
// list and FIFO, clears the current task and sets the idle id to zero.
`default_nettype none
`include "assert_macros.svh"

module timed_task_event_queue #(
   parameter int POST_DEPTH = tteq_pkg::POST_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [3:0]                   req_mode,
   input  wire logic [tteq_pkg::ID_W-1:0]    req_task_id,
   input  wire logic [tteq_pkg::TIME_W-1:0]  req_due_time,
   input  wire logic signed [31:0]           req_delay,
   input  wire logic [tteq_pkg::TIME_W-1:0]  req_now,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_err,
   output logic [1:0]                        rsp_dispatch_kind,
   output logic [tteq_pkg::ID_W-1:0]         rsp_dispatched_task,
   output logic [1:0]                        rsp_task_status,
   output logic                              rsp_found,
   output logic [tteq_pkg::CNT_W-1:0]        rsp_task_count,
   output logic                              rsp_head_valid,
   output logic [tteq_pkg::ID_W-1:0]         rsp_head_task,
   output logic [tteq_pkg::TIME_W-1:0]       rsp_head_time,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [tteq_pkg::ID_W-1:0]    csr_idle_task_id
);

   localparam logic [tteq_pkg::CNT_W-1:0] MaxCount = tteq_pkg::CNT_W'(tteq_pkg::MAX_TASKS);

   tteq_pkg::cmd_type  cmd;
   tteq_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   tteq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tteq_dpath #(
      .POST_DEPTH (POST_DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req_mode),
      .req_task_id         (req_task_id),
      .req_due_time        (req_due_time),
      .req_delay           (req_delay),
      .req_now             (req_now),
      .csr_valid           (csr_valid && csr_ready),
      .csr_idle_task_id    (csr_idle_task_id),
      .rsp_err             (rsp_err),
      .rsp_dispatch_kind   (rsp_dispatch_kind),
      .rsp_dispatched_task (rsp_dispatched_task),
      .rsp_task_status     (rsp_task_status),
      .rsp_found           (rsp_found),
      .rsp_task_count      (rsp_task_count),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_task       (rsp_head_task),
      .rsp_head_time       (rsp_head_time)
   );

   `ASSERT_CLK(a_rsp_single, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
   `ASSERT_ALWAYS(a_rsp_busy, rsp_valid |-> busy, "result shown while idle")
   `ASSERT_CLK(a_count_range, rsp_valid |-> (rsp_task_count <= MaxCount), "count beyond list")

endmodule

`default_nettype wire
